>>> rtl/core/cdt_pkg.sv
package cdt_pkg;

  // Key lanes, in the order their presses are handled
  localparam int unsigned KEY_COUNT = 3;
  localparam int unsigned KEY_START = 0;
  localparam int unsigned KEY_MODE  = 1;
  localparam int unsigned KEY_RESET = 2;

  // Field widths
  localparam int unsigned DEBOUNCE_W = 10;
  localparam int unsigned LOCKOUT_W  = 10;
  localparam int unsigned SECOND_W   = 11;
  localparam int unsigned MINUTES_W  = 7;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned PROG_W     = 6;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned KEY_AGE_W  = 11;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 48;

  localparam int unsigned PRESET_SLOTS = 5;
  localparam int unsigned MODE_COUNT_DEF = 5;

  // Saturation limits and constants
  localparam logic [KEY_AGE_W-1:0] KEY_AGE_MAX    = '1;
  localparam logic [LOCKOUT_W-1:0] TOGGLE_AGE_MAX = '1;
  localparam logic [SECOND_W-1:0]  PHASE_MAX      = '1;
  localparam logic [PROG_W-1:0]    PROG_LAST      = 6'd59;

  // Register reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd60;
  localparam logic [LOCKOUT_W-1:0]  LOCKOUT_RST  = 10'd250;
  localparam logic [SECOND_W-1:0]   SECOND_RST   = 11'd1000;
  localparam logic [PRESET_SLOTS-1:0][MINUTES_W-1:0] PRESET_RST =
    {7'd25, 7'd20, 7'd15, 7'd10, 7'd5};
  localparam logic [COUNT_W-1:0] SECONDS_LEFT_RST = 13'd300;

  // Reciprocal of 60: x * 8739 >> 19 is exact for any 13-bit x
  localparam logic [13:0] RECIP_60 = 14'd8739;
  localparam int unsigned RECIP_60_SHIFT = 19;
  // Reciprocal of 10: m * 205 >> 11 is exact for any 7-bit m
  localparam logic [7:0] RECIP_10 = 8'd205;
  localparam int unsigned RECIP_10_SHIFT = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 4'd0,
    REG_LOCKOUT  = 4'd1,
    REG_SECOND   = 4'd2,
    REG_MODE0    = 4'd3,
    REG_MODE1    = 4'd4,
    REG_MODE2    = 4'd5,
    REG_MODE3    = 4'd6,
    REG_MODE4    = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0]                     debounce_ms;
    logic [LOCKOUT_W-1:0]                      toggle_lockout_ms;
    logic [SECOND_W-1:0]                       second_ms;
    logic [PRESET_SLOTS-1:0][MINUTES_W-1:0]    preset_minutes;
  } cfg_t;

  // Timer state after one tick
  typedef struct packed {
    logic               running;
    logic [COUNT_W-1:0] seconds_left;
    logic [PROG_W-1:0]  progress;
    logic [MODE_W-1:0]  mode;
    logic               done;
  } status_t;

  // First display stage: whole minutes beside the status
  typedef struct packed {
    status_t              status;
    logic [MINUTES_W-1:0] minutes;
  } disp_t;

  // Seven-segment pattern, bit0 A through bit6 G, blank above nine
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

>>> rtl/core/cdt_key_lane.sv
module cdt_key_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic                             raw_i,
  input  logic [cdt_pkg::DEBOUNCE_W-1:0]   debounce_ms_i,
  output logic                             press_o
);
  import cdt_pkg::*;

  logic                 last_q, last_d;
  logic                 stable_q, stable_d;
  logic [KEY_AGE_W-1:0] age_q, age_d;
  logic [KEY_AGE_W-1:0] age_inc;
  logic                 flip;

  // Age the level, restart on a change, settle once old enough
  always_comb begin
    age_inc  = (age_q < KEY_AGE_MAX) ? age_q + 1'b1 : age_q;
    age_d    = (raw_i != last_q) ? '0 : age_inc;
    last_d   = raw_i;
    flip     = (age_d > KEY_AGE_W'(debounce_ms_i)) && (raw_i != stable_q);
    stable_d = flip ? raw_i : stable_q;
    press_o  = flip && !raw_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b1;
      stable_q <= 1'b1;
      age_q    <= '0;
    end else if (accept_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      age_q    <= age_d;
    end
  end

endmodule

>>> rtl/core/cdt_timer_core.sv
module cdt_timer_core #(
  parameter int unsigned MODE_COUNT = cdt_pkg::MODE_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [cdt_pkg::KEY_COUNT-1:0]  press_i,
  input  cdt_pkg::cfg_t                  cfg_i,
  output cdt_pkg::status_t               status_o
);
  import cdt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_LAST = MODE_W'(MODE_COUNT - 1);

  logic [LOCKOUT_W-1:0] toggle_age_q, toggle_age_d;
  logic [SECOND_W-1:0]  phase_q, phase_d;
  logic                 running_q, running_d;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [COUNT_W-1:0]   left_q, left_d;
  logic [COUNT_W-1:0]   elapsed_q, elapsed_d;
  logic [PROG_W-1:0]    prog_q, prog_d;
  logic                 done_q, done_d;
  logic                 mode_step;
  logic [MINUTES_W-1:0] preset;

  // Merge the key presses in order, then count a due second
  always_comb begin
    toggle_age_d = (toggle_age_q < TOGGLE_AGE_MAX) ? toggle_age_q + 1'b1 : toggle_age_q;
    phase_d      = (running_q && phase_q < PHASE_MAX) ? phase_q + 1'b1 : phase_q;
    running_d    = running_q;
    mode_d       = mode_q;
    left_d       = left_q;
    elapsed_d    = elapsed_q;
    prog_d       = prog_q;
    done_d       = 1'b0;

    if (press_i[KEY_START] && toggle_age_d >= cfg_i.toggle_lockout_ms) begin
      toggle_age_d = '0;
      running_d    = !running_d;
      if (running_d) begin
        phase_d = '0;
      end
    end

    mode_step = press_i[KEY_MODE] && !running_d;
    if (mode_step) begin
      mode_d = (mode_q == MODE_LAST) ? '0 : mode_q + 1'b1;
    end

    if (press_i[KEY_RESET]) begin
      running_d = 1'b0;
    end

    // Reload the selected preset
    preset = cfg_i.preset_minutes[mode_d];
    if (mode_step || press_i[KEY_RESET]) begin
      left_d    = COUNT_W'(COUNT_W'(preset) * COUNT_W'(60));
      elapsed_d = '0;
      prog_d    = '0;
    end

    if (running_d && phase_d >= cfg_i.second_ms) begin
      phase_d = '0;
      if (left_d != '0) begin
        left_d    = left_d - 1'b1;
        elapsed_d = elapsed_d + 1'b1;
        // Elapsed wraps to zero, and zero is a multiple of sixty
        prog_d    = (elapsed_d == '0 || prog_d == PROG_LAST) ? '0 : prog_d + 1'b1;
      end else begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toggle_age_q <= TOGGLE_AGE_MAX;
      phase_q      <= '0;
      running_q    <= 1'b0;
      mode_q       <= '0;
      left_q       <= SECONDS_LEFT_RST;
      elapsed_q    <= '0;
      prog_q       <= '0;
      done_q       <= 1'b0;
    end else if (accept_i) begin
      toggle_age_q <= toggle_age_d;
      phase_q      <= phase_d;
      running_q    <= running_d;
      mode_q       <= mode_d;
      left_q       <= left_d;
      elapsed_q    <= elapsed_d;
      prog_q       <= prog_d;
      done_q       <= done_d;
    end
  end

  assign status_o.running      = running_q;
  assign status_o.seconds_left = left_q;
  assign status_o.progress     = prog_q;
  assign status_o.mode         = mode_q;
  assign status_o.done         = done_q;

endmodule

>>> rtl/core/cdt_display.sv
module cdt_display (
  input  logic                              clk_i,
  input  logic                              en_b_i,
  input  logic                              en_c_i,
  input  cdt_pkg::status_t                  status_i,
  output logic [cdt_pkg::OUT_DATA_W-1:0]    tdata_o
);
  import cdt_pkg::*;

  logic [26:0]          min_prod;
  disp_t                disp_d, disp_q;
  logic [14:0]          tens_prod;
  logic [DIGIT_W-1:0]   tens;
  logic [MINUTES_W-1:0] tens_x10;
  logic [DIGIT_W-1:0]   ones;
  logic [OUT_DATA_W-1:0] data_d, data_q;

  // Stage B: whole minutes by reciprocal multiply
  always_comb begin
    min_prod       = 27'(status_i.seconds_left) * 27'(RECIP_60);
    disp_d.status  = status_i;
    disp_d.minutes = min_prod[RECIP_60_SHIFT +: MINUTES_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      disp_q <= disp_d;
    end
  end

  // Stage C: split minutes into digits and pack the transfer
  always_comb begin
    tens_prod = 15'(disp_q.minutes) * 15'(RECIP_10);
    tens      = tens_prod[RECIP_10_SHIFT +: DIGIT_W];
    tens_x10  = MINUTES_W'({tens, 3'b000}) + MINUTES_W'({tens, 1'b0});
    ones      = DIGIT_W'(disp_q.minutes - tens_x10);
    data_d    = {2'b00,
                 disp_q.status.done,
                 disp_q.status.mode,
                 disp_q.status.progress,
                 seg_of(ones),
                 seg_of(tens),
                 ones,
                 tens,
                 disp_q.status.seconds_left,
                 disp_q.status.running};
  end

  always_ff @(posedge clk_i) begin
    if (en_c_i) begin
      data_q <= data_d;
    end
  end

  assign tdata_o = data_q;

endmodule

>>> rtl/core/countdown_timer_with_debounced_keys.sv
// Countdown timer with three debounced keys, one millisecond tick per transfer.
// A result is offered on m_axis once its accepted tick has passed through every pipeline stage.
// Throughput: one tick per cycle; the state update, minute division and digit
// split each own one pipeline stage, and s_axis_tready stalls only with m_axis.
// Reset (async, active low) selects mode zero with 300 s left, stopped, keys
// released, registers at their defaults and the pipeline empty.
module countdown_timer_with_debounced_keys #(
  parameter int unsigned MODE_COUNT = cdt_pkg::MODE_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] start_key_level, [1] mode_key_level, [2] reset_key_level
  input  logic [cdt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] running, [13:1] remaining_seconds, [17:14] minutes_tens,
  // [21:18] minutes_ones, [28:22] tens_segments, [35:29] ones_segments,
  // [41:36] progress_count, [44:42] mode_number, [45] done_pulse
  output logic [cdt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [cdt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cdt_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import cdt_pkg::*;

  cfg_t                 cfg_q;
  status_t              status;
  logic [KEY_COUNT-1:0] press;
  logic                 accept;
  logic                 valid_a_q, valid_b_q, valid_c_q;
  logic                 adv_a, adv_b, adv_c;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms       <= DEBOUNCE_RST;
      cfg_q.toggle_lockout_ms <= LOCKOUT_RST;
      cfg_q.second_ms         <= SECOND_RST;
      cfg_q.preset_minutes    <= PRESET_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_DEBOUNCE: cfg_q.debounce_ms       <= cfg_data_i[DEBOUNCE_W-1:0];
        REG_LOCKOUT:  cfg_q.toggle_lockout_ms <= cfg_data_i[LOCKOUT_W-1:0];
        REG_SECOND:   cfg_q.second_ms         <= cfg_data_i[SECOND_W-1:0];
        REG_MODE0:    cfg_q.preset_minutes[0] <= cfg_data_i[MINUTES_W-1:0];
        REG_MODE1:    cfg_q.preset_minutes[1] <= cfg_data_i[MINUTES_W-1:0];
        REG_MODE2:    cfg_q.preset_minutes[2] <= cfg_data_i[MINUTES_W-1:0];
        REG_MODE3:    cfg_q.preset_minutes[3] <= cfg_data_i[MINUTES_W-1:0];
        REG_MODE4:    cfg_q.preset_minutes[4] <= cfg_data_i[MINUTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: each stage advances when the next one is free
  assign adv_c         = !valid_c_q || m_axis_tready;
  assign adv_b         = !valid_b_q || adv_c;
  assign adv_a         = !valid_a_q || adv_b;
  assign s_axis_tready = adv_a;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      valid_a_q <= accept || (valid_a_q && !adv_b);
      valid_b_q <= (valid_a_q && adv_b) || (valid_b_q && !adv_c);
      valid_c_q <= (valid_b_q && adv_c) || (valid_c_q && !m_axis_tready);
    end
  end

  assign m_axis_tvalid = valid_c_q;

  // One debounce lane per key
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    cdt_key_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .accept_i      (accept),
      .raw_i         (s_axis_tdata[k]),
      .debounce_ms_i (cfg_q.debounce_ms),
      .press_o       (press[k])
    );
  end

  // Merge presses into the timer state
  cdt_timer_core #(
    .MODE_COUNT (MODE_COUNT)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .press_i  (press),
    .cfg_i    (cfg_q),
    .status_o (status)
  );

  cdt_display u_display (
    .clk_i    (clk_i),
    .en_b_i   (adv_b),
    .en_c_i   (adv_c),
    .status_i (status),
    .tdata_o  (m_axis_tdata)
  );

  // Input stalls only behind a stalled output transfer
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // A finished countdown is never left running
  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> !status.running)
    else $error("done with timer still running");

  // Progress stays within one minute
  a_prog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.progress <= PROG_LAST)
    else $error("progress count out of range");

  // Mode index stays within the preset count
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.mode < MODE_W'(MODE_COUNT))
    else $error("mode index out of range");

endmodule
